>>> sv/ppr_pkg.sv
`default_nettype none

package ppr_pkg;

	localparam int COORD_WIDTH_DEF    = 32;
	localparam int ROTATION_STEPS_DEF = 18;

	localparam int HEAD_W = 19;          // Q3.16 heading
	localparam int ZW     = 33;          // Q30 angle accumulator, holds +-pi with sign
	localparam int GUARD  = 12;          // extra fraction bits carried through the datapath
	localparam int ATAN_STEPS = 32;

	localparam logic signed [HEAD_W-1:0] HEAD_MAX = 19'sd205888;
	localparam logic signed [ZW-1:0]     HALF_PI_Q30 = 33'sd1686629713;

	// CORDIC gain 0.607252935 in Q30, split into a high and a low 15-bit part
	localparam logic [14:0] GAIN_HI = 15'd19898;
	localparam logic [14:0] GAIN_LO = 15'd15210;

	// atan(2^-i) in Q30, truncated
	localparam logic [31:0] ATAN_Q30 [ATAN_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
		32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
	};

endpackage

`default_nettype wire

>>> sv/ppr_ifs.sv
`default_nettype none

interface ppr_pnt_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic                func;
	logic signed [W-1:0] point_x;
	logic signed [W-1:0] point_y;
	logic signed [18:0]  heading;

	modport source (output valid, output func, output point_x, output point_y,
		output heading, input ready);
	modport sink (input valid, input func, input point_x, input point_y,
		input heading, output ready);
endinterface

interface ppr_rot_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] rotated_x;
	logic signed [W-1:0] rotated_y;
	logic                saturated;

	modport source (output valid, output rotated_x, output rotated_y,
		output saturated, input ready);
	modport sink (input valid, input rotated_x, input rotated_y,
		input saturated, output ready);
endinterface

`default_nettype wire

>>> sv/planar_point_rotator.sv
// Planar point rotator: turns a Q16.16 point by a Q3.16 heading using a CORDIC pipeline.
// Input channel pnt carries func, point_x, point_y and heading; a transaction is taken
// on a clock edge with valid and ready high. func 0 rotates clockwise into the fixed
// frame, func 1 rotates back. The heading is clamped to +-pi.
// Output channel rot carries rotated_x, rotated_y (rounded, saturated) and saturated.
// The pipeline has one stage for clamp and magnitude, one for the gain multiply, one for
// the gain sum and sign, one for the quadrant fold, one per CORDIC iteration, and the
// round/saturate output register. Throughput is one transaction per cycle while the
// output is not stalled; every stage is a register with a valid bit.
// When the receiver stalls with a result waiting, the whole pipeline holds and pnt.ready
// drops in the same cycle; nothing is lost or repeated, and bubbles move along with data.
// arst_n clears all valid bits at once, so no result appears until a new transaction.
// There is no configuration and no state kept between transactions.
`default_nettype none

module planar_point_rotator
	import ppr_pkg::*;
#(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ppr_pnt_if.sink    pnt,
	ppr_rot_if.source  rot
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = W + 15;      // gain partial product
	localparam int MW = W + 12;      // scaled magnitude
	localparam int XW = W + 14;      // signed datapath with headroom for CORDIC growth
	localparam int RW = XW - GUARD;  // rounded result before saturation

	// Advance the whole pipeline unless a finished result is waiting.
	logic en;
	assign en        = !rot.valid || rot.ready;
	assign pnt.ready = en;

	// ---- stage 1: clamp heading, pick direction, take magnitudes ----
	logic signed [HEAD_W-1:0] h_clamp, h_dir;
	logic        [W-1:0]      ax_c, ay_c;

	always_comb begin
		if (pnt.heading > HEAD_MAX) begin
			h_clamp = HEAD_MAX;
		end else if (pnt.heading < -HEAD_MAX) begin
			h_clamp = -HEAD_MAX;
		end else begin
			h_clamp = pnt.heading;
		end
		// func 0 rotates clockwise: negate the angle
		h_dir = pnt.func ? h_clamp : -h_clamp;
		ax_c  = pnt.point_x[W-1] ? (~pnt.point_x + W'(1)) : pnt.point_x;
		ay_c  = pnt.point_y[W-1] ? (~pnt.point_y + W'(1)) : pnt.point_y;
	end

	logic                 v_s1, sx_s1, sy_s1;
	logic        [W-1:0]  ax_s1, ay_s1;
	logic signed [ZW-1:0] z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= pnt.point_x[W-1];
			sy_s1 <= pnt.point_y[W-1];
			ax_s1 <= ax_c;
			ay_s1 <= ay_c;
			z_s1  <= {h_dir, 14'b0};   // Q3.16 -> Q30
		end
	end

	// ---- stage 2: gain multiply, split into high and low 15-bit parts ----
	logic                 v_s2, sx_s2, sy_s2;
	logic        [PW-1:0] phx_s2, plx_s2, phy_s2, ply_s2;
	logic signed [ZW-1:0] z_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			phx_s2 <= PW'(ax_s1) * PW'(GAIN_HI);
			plx_s2 <= PW'(ax_s1) * PW'(GAIN_LO);
			phy_s2 <= PW'(ay_s1) * PW'(GAIN_HI);
			ply_s2 <= PW'(ay_s1) * PW'(GAIN_LO);
			z_s2   <= z_s1;
		end
	end

	// ---- stage 3: sum the partials, restore the sign (truncates toward zero) ----
	logic [MW-1:0] mx_c, my_c;
	assign mx_c = MW'(phx_s2 >> 3) + MW'(plx_s2 >> 18);
	assign my_c = MW'(phy_s2 >> 3) + MW'(ply_s2 >> 18);

	logic                 v_s3;
	logic signed [XW-1:0] x_s3, y_s3;
	logic signed [ZW-1:0] z_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= sx_s2 ? -$signed({2'b00, mx_c}) : $signed({2'b00, mx_c});
			y_s3 <= sy_s2 ? -$signed({2'b00, my_c}) : $signed({2'b00, my_c});
			z_s3 <= z_s2;
		end
	end

	// ---- stage 4: fold angles beyond +-pi/2 by a quarter turn ----
	logic                 v_s4;
	logic signed [XW-1:0] x_s4, y_s4;
	logic signed [ZW-1:0] z_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_s3 > HALF_PI_Q30) begin
				x_s4 <= -y_s3;
				y_s4 <= x_s3;
				z_s4 <= z_s3 - HALF_PI_Q30;
			end else if (z_s3 < -HALF_PI_Q30) begin
				x_s4 <= y_s3;
				y_s4 <= -x_s3;
				z_s4 <= z_s3 + HALF_PI_Q30;
			end else begin
				x_s4 <= x_s3;
				y_s4 <= y_s3;
				z_s4 <= z_s3;
			end
		end
	end

	// Valid bits for the front stages; only these need reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pnt.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ---- CORDIC iterations: one register stage per step ----
	logic                 v_it [ROTATION_STEPS+1];
	logic signed [XW-1:0] x_it [ROTATION_STEPS+1];
	logic signed [XW-1:0] y_it [ROTATION_STEPS+1];
	logic signed [ZW-1:0] z_it [ROTATION_STEPS+1];

	assign v_it[0] = v_s4;
	assign x_it[0] = x_s4;
	assign y_it[0] = y_s4;
	assign z_it[0] = z_s4;

	for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_step
		ppr_cordic_stage #(
			.XW   (XW),
			.STEP (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (v_it[i]),
			.x_in      (x_it[i]),
			.y_in      (y_it[i]),
			.z_in      (z_it[i]),
			.valid_out (v_it[i+1]),
			.x_out     (x_it[i+1]),
			.y_out     (y_it[i+1]),
			.z_out     (z_it[i+1])
		);
	end

	// ---- output stage: round off the guard bits, saturate, flag ----
	logic signed [XW-1:0] xr_c, yr_c;
	logic signed [RW-1:0] xq_c, yq_c;
	logic                 xo_c, yo_c;
	logic signed [W-1:0]  xs_c, ys_c;

	localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	always_comb begin
		xr_c = x_it[ROTATION_STEPS] + XW'(1 << (GUARD - 1));
		yr_c = y_it[ROTATION_STEPS] + XW'(1 << (GUARD - 1));
		xq_c = xr_c[XW-1:GUARD];
		yq_c = yr_c[XW-1:GUARD];
		// out of range when the bits above the result width are not all sign
		xo_c = !((&xq_c[RW-1:W-1]) || !(|xq_c[RW-1:W-1]));
		yo_c = !((&yq_c[RW-1:W-1]) || !(|yq_c[RW-1:W-1]));
		xs_c = xo_c ? (xq_c[RW-1] ? MIN_V : MAX_V) : xq_c[W-1:0];
		ys_c = yo_c ? (yq_c[RW-1] ? MIN_V : MAX_V) : yq_c[W-1:0];
	end

	logic v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_it[ROTATION_STEPS];
		end
	end

	logic signed [W-1:0] rx_s5, ry_s5;
	logic                sat_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s5  <= xs_c;
			ry_s5  <= ys_c;
			sat_s5 <= xo_c || yo_c;
		end
	end

	assign rot.valid     = v_s5;
	assign rot.rotated_x = rx_s5;
	assign rot.rotated_y = ry_s5;
	assign rot.saturated = sat_s5;

endmodule

`default_nettype wire

>>> sv/ppr_cordic_stage.sv
`default_nettype none

module ppr_cordic_stage
	import ppr_pkg::*;
#(
	parameter int XW   = 46,
	parameter int STEP = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid_in,
	input  wire logic signed [XW-1:0] x_in,
	input  wire logic signed [XW-1:0] y_in,
	input  wire logic signed [ZW-1:0] z_in,
	output logic                      valid_out,
	output logic signed [XW-1:0]      x_out,
	output logic signed [XW-1:0]      y_out,
	output logic signed [ZW-1:0]      z_out
);

	localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_Q30[STEP]);

	logic                 valid_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic signed [XW-1:0] dx, dy;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// rotate toward zero residual angle; both updates use the old x and y
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[ZW-1]) begin
				x_s1 <= x_in - dx;
				y_s1 <= y_in + dy;
				z_s1 <= z_in - ANGLE;
			end else begin
				x_s1 <= x_in + dx;
				y_s1 <= y_in - dy;
				z_s1 <= z_in + ANGLE;
			end
		end
	end

	assign valid_out = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign z_out     = z_s1;

endmodule

`default_nettype wire

>>> sv/ppr_checker.sv
`default_nettype none

module ppr_checker #(
	parameter int W = 32
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                pnt_ready,
	input wire logic                rot_valid,
	input wire logic                rot_ready,
	input wire logic signed [W-1:0] rot_x,
	input wire logic signed [W-1:0] rot_y,
	input wire logic                rot_sat
);

	localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	// a waiting result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rot_valid && !rot_ready |=> rot_valid)
		else $error("result dropped while stalled");

	// a stalled output freezes the pipeline, so intake must stop
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		rot_valid && !rot_ready |-> !pnt_ready)
		else $error("input taken while output stalled");

	// the flag implies a coordinate sits at a range limit
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rot_valid && rot_sat |-> rot_x == MAX_V || rot_x == MIN_V ||
			rot_y == MAX_V || rot_y == MIN_V)
		else $error("saturation flag without a clamped coordinate");

	// nothing is offered during reset
	a_rst: assert property (@(posedge clk)
		!arst_n |-> !rot_valid)
		else $error("result offered during reset");

endmodule

bind planar_point_rotator ppr_checker #(
	.W (COORD_WIDTH)
) u_ppr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pnt_ready (pnt.ready),
	.rot_valid (rot.valid),
	.rot_ready (rot.ready),
	.rot_x     (rot.rotated_x),
	.rot_y     (rot.rotated_y),
	.rot_sat   (rot.saturated)
);

`default_nettype wire
